// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/sirdec_pkg.sv -----
package sirdec_pkg;

    localparam int MAX_READ_BYTES_DEF = 1024;

    // result queue, must be a power of two and at least 2
    localparam int Q_DEPTH = 4;

    localparam logic [7:0]  BEGIN_CODE_RST  = 8'hC0;
    localparam logic [7:0]  END_CODE_RST    = 8'hC1;
    localparam logic [7:0]  ESCAPE_CODE_RST = 8'h7D;
    localparam logic [7:0]  PAD_BYTE        = 8'hFF;
    localparam logic [7:0]  ESC_XOR         = 8'h20;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h8408;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        CFG_BEGIN  = 2'd0,
        CFG_END    = 2'd1,
        CFG_ESCAPE = 2'd2,
        CFG_SPARE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_PAD  = 2'd0,
        PH_BOFS = 2'd1,
        PH_CTRL = 2'd2,
        PH_BODY = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TIMEOUT   = 3'd1,
        ST_READ_ERR  = 3'd2,
        ST_MALFORMED = 3'd3,
        ST_CRC_FAIL  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       timed_out;
    } t_req;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] data_byte;
        logic [7:0] address;
        logic [7:0] control;
        logic [2:0] status;
        logic       last;
    } t_res;

    // up to two results written per accepted request
    typedef struct packed {
        logic wr0;
        logic wr1;
        t_res item0;
        t_res item1;
    } t_q_wr;

endpackage

// ----- rtl/core/sir_async_frame_decoder.sv -----
// Receive deframer for an asynchronous SIR-style link. One request (a raw byte or a
// read timeout) is taken per clock while o_stall is low; its frame state update,
// unescape and byte-wise CRC-16/X.25 step all finish in that cycle, and its results
// (none, one data byte, one status, or a data byte followed by a status) are written
// to a four-entry result queue whose head drives the output. o_stall rises only
// while the result queue has fewer than two free entries, so it follows downstream
// back-pressure. Data bytes leave two body bytes late, since the last two bytes
// are the CRC. The user must write codes through the configuration port only while
// the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module sir_async_frame_decoder import sirdec_pkg::*; #(
    parameter int MAX_READ_BYTES = MAX_READ_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_req       i_req,
    output logic       o_valid,
    input  logic       i_stall,
    output t_res       o_res,
    input  logic       i_cfg_we,
    input  t_cfg_idx   i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    localparam int RawW = $clog2(MAX_READ_BYTES);

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic [7:0]      r_begin_code, r_end_code, r_escape_code;

    t_phase          r_phase, n_phase;
    logic [RawW-1:0] r_raw_cnt, n_raw_cnt;
    logic [1:0]      r_body_cnt, n_body_cnt;   // saturates at three
    logic [15:0]     r_crc, n_crc;
    logic [7:0]      r_hold0, n_hold0;
    logic [7:0]      r_hold1, n_hold1;
    logic [1:0]      r_hold_cnt, n_hold_cnt;
    logic            r_esc_pend, n_esc_pend;
    logic            r_start_err, n_start_err;
    logic [7:0]      r_addr, n_addr;
    logic [7:0]      r_ctl, n_ctl;

    logic            acc;
    logic [7:0]      rx;
    logic            is_close;
    logic            overlong;
    logic            body_full;
    logic            push_en;
    logic            push_emit;
    logic [7:0]      push_byte;
    logic [7:0]      p_hold0, p_hold1;
    logic [1:0]      p_hold_cnt;
    logic [15:0]     p_crc;
    logic [15:0]     crc_upd;
    logic            do_clear;
    t_res            data_item;
    t_res            stat_item;
    t_status         stat;
    t_q_wr           q_wr;
    logic            q_almost_full;

    assign acc     = i_valid && !o_stall;
    assign o_stall = q_almost_full;
    assign rx      = i_req.rx_byte;

    assign is_close  = i_req.timed_out || (rx == r_end_code);
    assign overlong  = !is_close && (r_raw_cnt == RawW'(MAX_READ_BYTES - 1));
    assign body_full = (r_raw_cnt != '0) && !r_start_err && (r_phase != PH_PAD)
                       && (r_body_cnt == 2'd3);

    // a pending escape at close is kept as a literal escape byte
    always_comb begin
        if (is_close) begin
            push_en   = body_full && r_esc_pend;
            push_byte = r_escape_code;
        end else begin
            push_en   = !overlong && !r_start_err && (r_phase == PH_BODY)
                        && (r_esc_pend || (rx != r_escape_code));
            push_byte = r_esc_pend ? (rx ^ ESC_XOR) : rx;
        end
    end

    assign push_emit = push_en && (r_hold_cnt == 2'd2);
    assign crc_upd   = crc_byte(r_crc, push_emit ? r_hold0 : rx);

    // two-byte hold after this request's push
    always_comb begin
        p_hold0    = r_hold0;
        p_hold1    = r_hold1;
        p_hold_cnt = r_hold_cnt;
        p_crc      = r_crc;
        if (push_emit) begin
            p_hold0 = r_hold1;
            p_hold1 = push_byte;
            p_crc   = crc_upd;
        end else if (push_en) begin
            if (r_hold_cnt[0]) begin
                p_hold1 = push_byte;
            end else begin
                p_hold0 = push_byte;
            end
            p_hold_cnt = r_hold_cnt + 2'd1;
        end
    end

    always_comb begin
        data_item           = '0;
        data_item.item_kind = KIND_DATA;
        data_item.data_byte = r_hold0;

        priority if (r_raw_cnt == '0) begin
            stat = ST_TIMEOUT;
        end else if (r_start_err || (r_phase == PH_PAD)) begin
            stat = ST_READ_ERR;
        end else if ((r_body_cnt != 2'd3) || (p_hold_cnt != 2'd2)) begin
            stat = ST_MALFORMED;
        end else if ({p_hold1, p_hold0} == ~p_crc) begin
            stat = ST_OK;
        end else begin
            stat = ST_CRC_FAIL;
        end

        stat_item           = '0;
        stat_item.item_kind = KIND_STATUS;
        stat_item.last      = 1'b1;
        if (overlong) begin
            stat_item.status = ST_READ_ERR;
        end else begin
            stat_item.status = stat;
            if (stat != ST_TIMEOUT && stat != ST_READ_ERR) begin
                stat_item.address = r_addr;
                stat_item.control = r_ctl;
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_raw_cnt   = r_raw_cnt;
        n_body_cnt  = r_body_cnt;
        n_crc       = r_crc;
        n_hold0     = p_hold0;
        n_hold1     = p_hold1;
        n_hold_cnt  = r_hold_cnt;
        n_esc_pend  = r_esc_pend;
        n_start_err = r_start_err;
        n_addr      = r_addr;
        n_ctl       = r_ctl;
        do_clear    = 1'b0;
        q_wr        = '0;

        if (is_close) begin
            do_clear = 1'b1;
            if (push_emit) begin
                q_wr.wr0   = 1'b1;
                q_wr.item0 = data_item;
                q_wr.wr1   = 1'b1;
                q_wr.item1 = stat_item;
            end else begin
                q_wr.wr0   = 1'b1;
                q_wr.item0 = stat_item;
            end
        end else if (overlong) begin
            do_clear   = 1'b1;
            q_wr.wr0   = 1'b1;
            q_wr.item0 = stat_item;
        end else begin
            n_raw_cnt = r_raw_cnt + RawW'(1);
            if (!r_start_err) begin
                unique case (r_phase)
                    PH_PAD: begin
                        if (rx != PAD_BYTE) begin
                            if (rx == r_begin_code) begin
                                n_phase = PH_BOFS;
                            end else begin
                                n_start_err = 1'b1;
                            end
                        end
                    end
                    PH_BOFS: begin
                        if (rx != r_begin_code) begin
                            n_addr     = rx;
                            n_crc      = crc_upd;
                            n_body_cnt = 2'd1;
                            n_phase    = PH_CTRL;
                        end
                    end
                    PH_CTRL: begin
                        n_ctl      = rx;
                        n_crc      = crc_upd;
                        n_body_cnt = 2'd2;
                        n_phase    = PH_BODY;
                    end
                    PH_BODY: begin
                        if (r_body_cnt != 2'd3) begin
                            n_body_cnt = r_body_cnt + 2'd1;
                        end
                        n_esc_pend = !r_esc_pend && (rx == r_escape_code);
                        n_crc      = p_crc;
                        n_hold_cnt = p_hold_cnt;
                        if (push_emit) begin
                            q_wr.wr0        = 1'b1;
                            q_wr.item0      = data_item;
                            q_wr.item0.last = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_PAD;
                    end
                endcase
            end
        end

        if (do_clear) begin
            n_phase     = PH_PAD;
            n_raw_cnt   = '0;
            n_body_cnt  = '0;
            n_crc       = CRC_INIT;
            n_hold_cnt  = '0;
            n_esc_pend  = 1'b0;
            n_start_err = 1'b0;
            n_addr      = '0;
            n_ctl       = '0;
        end

        if (!acc) begin
            q_wr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PAD;
            r_raw_cnt   <= '0;
            r_body_cnt  <= '0;
            r_crc       <= CRC_INIT;
            r_hold_cnt  <= '0;
            r_esc_pend  <= 1'b0;
            r_start_err <= 1'b0;
            r_addr      <= '0;
            r_ctl       <= '0;
        end else if (acc) begin
            r_phase     <= n_phase;
            r_raw_cnt   <= n_raw_cnt;
            r_body_cnt  <= n_body_cnt;
            r_crc       <= n_crc;
            r_hold_cnt  <= n_hold_cnt;
            r_esc_pend  <= n_esc_pend;
            r_start_err <= n_start_err;
            r_addr      <= n_addr;
            r_ctl       <= n_ctl;
        end
    end

    // hold bytes are only read once both have been written
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_hold0 <= n_hold0;
            r_hold1 <= n_hold1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_code  <= BEGIN_CODE_RST;
            r_end_code    <= END_CODE_RST;
            r_escape_code <= ESCAPE_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BEGIN:  r_begin_code  <= i_cfg_data;
                CFG_END:    r_end_code    <= i_cfg_data;
                CFG_ESCAPE: r_escape_code <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sirdec_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (q_wr),
        .o_almost_full (q_almost_full),
        .o_valid       (o_valid),
        .o_res         (o_res),
        .i_stall       (i_stall)
    );

    `ASSERT_RUN(a_hold_cnt_max, i_clk, i_rst_n, (r_hold_cnt != 2'd3), "hold count overran")
    `ASSERT_RUN(a_esc_in_body, i_clk, i_rst_n, (r_esc_pend |-> (r_phase == PH_BODY)),
                "escape pending outside body")
    `ASSERT_RUN(a_serr_in_pad, i_clk, i_rst_n, (r_start_err |-> (r_phase == PH_PAD)),
                "start error outside padding")
    `ASSERT_RUN(a_close_gives_res, i_clk, i_rst_n, ((acc && i_req.timed_out) |=> o_valid),
                "timeout gave no status")
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, (!i_rst_n |=> !o_valid), "result shown after reset")

endmodule

// ----- rtl/core/sirdec_outq.sv -----
module sirdec_outq import sirdec_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_wr,
    output logic  o_almost_full,
    output logic  o_valid,
    output t_res  o_res,
    input  logic  i_stall
);

    localparam int PtrW = $clog2(Q_DEPTH);
    localparam int CntW = $clog2(Q_DEPTH + 1);

    t_res            r_mem [Q_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            pop;
    logic [PtrW-1:0] wr_ptr1;

    assign pop           = (r_count != '0) && !i_stall;
    assign wr_ptr1       = r_wr_ptr + PtrW'(1);
    assign o_valid       = (r_count != '0);
    assign o_res         = r_mem[r_rd_ptr];
    // room for two results is kept so a request never has to be refused halfway
    assign o_almost_full = (r_count > CntW'(Q_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + PtrW'(i_wr.wr0) + PtrW'(i_wr.wr1);
        n_rd_ptr = r_rd_ptr + PtrW'(pop);
        n_count  = r_count + CntW'(i_wr.wr0) + CntW'(i_wr.wr1) - CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr0) begin
            r_mem[r_wr_ptr] <= i_wr.item0;
        end
        if (i_wr.wr1) begin
            r_mem[wr_ptr1] <= i_wr.item1;
        end
    end

endmodule
